>>> src/bsr_pkg.sv
// Package for the bisection square root block.
// Holds the tolerance register width and reset value; no dependencies.
package bsr_pkg;

    localparam int TOL_W = 6;
    localparam logic [TOL_W-1:0] TOL_RESET = 6'd30;

    typedef logic [TOL_W-1:0] tol_shift_t;

endpackage

>>> src/bsr_in_if.sv
// Operand channel interface: valid, ready and the operand payload.
// Standalone; width set by DATA_WIDTH.
interface bsr_in_if #(
    parameter int DATA_WIDTH = 64
) ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

>>> src/bsr_out_if.sv
// Result channel interface: valid, ready, root and exact_hit.
// Standalone; width set by DATA_WIDTH.
interface bsr_out_if #(
    parameter int DATA_WIDTH = 64
) ();
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] root;
    logic                  exact_hit;

    modport source (output valid, output root, output exact_hit, input ready);
    modport sink   (input valid, input root, input exact_hit, output ready);
endinterface

>>> src/bsr_cfg_if.sv
// Configuration write channel carrying the tolerance shift register.
// Depends on bsr_pkg for the register type.
interface bsr_cfg_if import bsr_pkg::*; ();
    logic       valid;
    logic       ready;
    tol_shift_t tolerance_shift;

    modport source (output valid, output tolerance_shift, input ready);
    modport sink   (input valid, input tolerance_shift, output ready);
endinterface

>>> src/bsr_square_unit.sv
// Fixed-point squarer: one shared half-width multiplier over three partial
// products, accumulated and saturated. Standalone; started by the sequencer.
module bsr_square_unit #(
    parameter int DATA_WIDTH = 64,
    parameter int FRAC_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] mid,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] square
);

    localparam int H  = (DATA_WIDTH + 1) / 2;
    localparam int PW = 2 * DATA_WIDTH;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CROSS = 3'd1;
    localparam logic [2:0] PH_HIGH  = 3'd2;
    localparam logic [2:0] PH_LAST  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    logic [2:0]    phase_reg, phase_next;
    logic [2*H-1:0] pp_reg, pp_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [H-1:0]  lo_half, hi_half, mul_a, mul_b;
    logic [2*H-1:0] prod;

    assign lo_half = mid[H-1:0];
    assign hi_half = H'(mid >> H);
    assign mul_a   = (phase_reg == PH_IDLE) ? lo_half : hi_half;
    assign mul_b   = (phase_reg == PH_HIGH) ? hi_half : lo_half;
    assign prod    = (2*H)'(mul_a) * (2*H)'(mul_b);

    always_comb
    begin
        phase_next = phase_reg;
        pp_next    = pp_reg;
        acc_next   = acc_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    pp_next    = prod;
                    acc_next   = '0;
                    phase_next = PH_CROSS;
                end
            end
            PH_CROSS:
            begin
                pp_next    = prod;
                acc_next   = acc_reg + PW'(pp_reg);
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                pp_next    = prod;
                acc_next   = acc_reg + (PW'(pp_reg) << (H + 1));
                phase_next = PH_LAST;
            end
            PH_LAST:
            begin
                acc_next   = acc_reg + (PW'(pp_reg) << (2 * H));
                phase_next = PH_DONE;
            end
            PH_DONE:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign done   = (phase_reg == PH_DONE);
    assign square = (|acc_reg[PW-1:DATA_WIDTH+FRAC_BITS]) ? '1
                  : acc_reg[DATA_WIDTH+FRAC_BITS-1:FRAC_BITS];

endmodule

>>> src/bisection_square_root.sv
// Bisection square root, top level: sequencer, bounds and output register.
// A search runs up to about 64 rounds from acceptance to result; a round is a bound
// check, a squarer start and a wait for its done, and a midpoint match ends it early.
// Operands: one at a time, taken only when idle; emit stalls while a result still waits.
// Reset: asynchronous active low; idle, no result pending, tolerance shift 30.
// Depends on bsr_pkg, bsr_in_if, bsr_out_if, bsr_cfg_if and bsr_square_unit.
module bisection_square_root import bsr_pkg::*; #(
    parameter int DATA_WIDTH = 64,
    parameter int FRAC_BITS  = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    bsr_in_if.sink   request,
    bsr_out_if.source result,
    bsr_cfg_if.sink  cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

    logic [2:0]            state_reg, state_next;
    tol_shift_t            tol_reg;
    logic [DATA_WIDTH-1:0] lo_reg, lo_next;
    logic [DATA_WIDTH-1:0] hi_reg, hi_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] mid_reg, mid_next;
    logic                  hit_reg, hit_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_root_reg, out_root_next;
    logic                  out_hit_reg, out_hit_next;

    logic                  sq_done;
    logic [DATA_WIDTH-1:0] sq;
    logic [DATA_WIDTH-1:0] span, span_tol, sq_diff, sq_tol;
    logic                  keep_going, out_free;

    bsr_square_unit #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_square (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_START),
        .mid    (mid_reg),
        .done   (sq_done),
        .square (sq)
    );

    assign span       = hi_reg - lo_reg;
    assign span_tol   = hi_reg >> tol_reg;
    assign keep_going = (span > span_tol) && (span > DATA_WIDTH'(1));
    assign sq_diff    = (sq >= x_reg) ? (sq - x_reg) : (x_reg - sq);
    assign sq_tol     = x_reg >> tol_reg;
    assign out_free   = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_root_next  = out_root_reg;
        out_hit_next   = out_hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (request.valid)
                begin
                    x_next = request.operand;
                    if (request.operand < ONE)
                    begin
                        lo_next = request.operand;
                        hi_next = ONE;
                    end
                    else
                    begin
                        lo_next = ONE;
                        hi_next = request.operand;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (keep_going)
                begin
                    mid_next   = lo_reg + (span >> 1);
                    state_next = S_START;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sq_done)
                begin
                    if (sq_diff <= sq_tol)
                    begin
                        hit_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        if (sq > x_reg)
                            hi_next = mid_reg;
                        else
                            lo_next = mid_reg;
                        state_next = S_CHECK;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_root_next  = hit_reg ? mid_reg : lo_reg;
                    out_hit_next   = hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            tol_reg       <= TOL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                tol_reg <= cfg.tolerance_shift;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        x_reg        <= x_next;
        mid_reg      <= mid_next;
        hit_reg      <= hit_next;
        out_root_reg <= out_root_next;
        out_hit_reg  <= out_hit_next;
    end

    assign request.ready    = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.root      = out_root_reg;
    assign result.exact_hit = out_hit_reg;

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK || state_reg == S_WAIT) |-> (lo_reg <= hi_reg))
        else $error("search bounds crossed");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (mid_reg >= lo_reg && mid_reg <= hi_reg))
        else $error("midpoint outside search interval");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_WAIT))
        else $error("squarer finished outside wait state");

    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> (state_reg == S_CHECK))
        else $error("accepted transaction did not start a search");

endmodule

>>> bench/tb_bisection_square_root.sv
// Testbench for bisection_square_root: a directed table, then random operands under set
// and random tolerances, checked against a local bisection predictor or a typed root.
// Depends on bsr_pkg, bsr_in_if, bsr_out_if, bsr_cfg_if and the block itself.
module tb_bisection_square_root;
    import bsr_pkg::*;

    localparam int DATA_WIDTH = 64;
    localparam int FRAC_BITS = 32;
    localparam logic [63:0] ONE = 64'h1 << FRAC_BITS;
    localparam logic [63:0] ALL_ONES = '1;
    localparam int unsigned CYCLE_LIMIT = 2500000;
    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int DIRECTED_ROWS = 25;

    typedef enum logic [1:0] {ORD_SMALLER, ORD_EQUAL, ORD_LARGER} order_t;

    typedef struct packed {
        logic [63:0] root;
        logic        exact_hit;
    } root_t;

    typedef struct packed {
        tol_shift_t  k;
        logic [63:0] operand;
        logic        typed;
        logic [63:0] root;
        logic        exact_hit;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bsr_in_if #(.DATA_WIDTH(DATA_WIDTH)) request_if ();
    bsr_out_if #(.DATA_WIDTH(DATA_WIDTH)) result_if ();
    bsr_cfg_if cfg_if ();

    bisection_square_root #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    tol_shift_t  tol_model;
    logic [63:0] bound_low;
    logic [63:0] bound_high;
    logic [63:0] last_operand;
    root_t       pending_roots[$];
    int unsigned error_count;
    int unsigned cycle_count;
    dir_row_t    directed_rows[DIRECTED_ROWS];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [63:0] square_q(input logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, m} * {64'd0, m};
        prod = prod >> FRAC_BITS;
        if (prod[127:64] != 64'd0)
            return ALL_ONES;
        return prod[63:0];
    endfunction

    function automatic order_t rel_order(input logic [63:0] a, input logic [63:0] b,
                                         input tol_shift_t k);
        logic [63:0] diff;
        diff = (a >= b) ? a - b : b - a;
        if (diff <= (b >> k))
            return ORD_EQUAL;
        return (a > b) ? ORD_LARGER : ORD_SMALLER;
    endfunction

    function automatic root_t search_root(input logic [63:0] x, input tol_shift_t k);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        order_t      ord;
        root_t       r;
        if (x < ONE)
        begin
            lo = x;
            hi = ONE;
        end
        else
        begin
            lo = ONE;
            hi = x;
        end
        r.root = lo;
        r.exact_hit = 1'b0;
        while (!r.exact_hit && rel_order(lo, hi, k) == ORD_SMALLER && hi - lo > 64'd1)
        begin
            mid = lo + ((hi - lo) >> 1);
            ord = rel_order(square_q(mid), x, k);
            if (ord == ORD_EQUAL)
            begin
                r.root = mid;
                r.exact_hit = 1'b1;
            end
            else if (ord == ORD_LARGER)
                hi = mid;
            else
                lo = mid;
        end
        if (!r.exact_hit)
            r.root = lo;
        bound_low = lo;
        bound_high = hi;
        last_operand = x;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s expected %h actual %h", what, want, got);
    endtask

    task automatic wait_drained();
        while (pending_roots.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tolerance(input tol_shift_t k);
        cfg_if.valid <= 1'b1;
        cfg_if.tolerance_shift <= k;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        tol_model = k;
    endtask

    int unsigned source_calm;

    task automatic send_operand(input logic [63:0] x, input logic typed,
                                input logic [63:0] typed_root, input logic typed_hit);
        int unsigned hold;
        root_t       want;
        if (source_calm != 0)
        begin
            source_calm--;
            hold = 0;
        end
        else
        begin
            hold = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0)
                source_calm = $urandom_range(10, 30);
        end
        if (hold != 0)
        begin
            request_if.valid <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        request_if.valid <= 1'b1;
        request_if.operand <= x;
        do
            @(posedge clk);
        while (!request_if.ready);
        want = search_root(x, tol_model);
        if (typed)
        begin
            want.root = typed_root;
            want.exact_hit = typed_hit;
        end
        pending_roots.push_back(want);
        request_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : result_sink
        int unsigned hold;
        int unsigned sink_calm;
        root_t       want;
        sink_calm = 0;
        @(posedge rst_n);
        forever
        begin
            if (sink_calm != 0)
            begin
                sink_calm--;
                hold = 0;
            end
            else
            begin
                hold = $urandom_range(0, 8);
                if ($urandom_range(0, 15) == 0)
                    sink_calm = $urandom_range(10, 30);
            end
            if (hold != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
            if (pending_roots.size() == 0)
                note_mismatch("unexpected result, root", 64'd0, result_if.root);
            else
            begin
                want = pending_roots.pop_front();
                if (result_if.root !== want.root)
                    note_mismatch("root", want.root, result_if.root);
                if (result_if.exact_hit !== want.exact_hit)
                    note_mismatch("exact_hit", 64'(want.exact_hit), 64'(result_if.exact_hit));
            end
        end
    end

    initial
    begin : operand_source
        logic [63:0] x;
        logic [63:0] m;
        tol_shift_t  k;
        int unsigned phase;
        int unsigned n;
        rst_n <= 1'b0;
        request_if.valid <= 1'b0;
        request_if.operand <= '0;
        result_if.ready <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.tolerance_shift <= TOL_RESET;
        tol_model = TOL_RESET;
        error_count = 0;
        cycle_count = 0;
        source_calm = 0;
        directed_rows = '{
            '{6'd30, ONE,                   1'b1, ONE,            1'b0},
            '{6'd30, 64'd0,                 1'b0, 64'd0,          1'b0},
            '{6'd30, 64'd1,                 1'b0, 64'd0,          1'b0},
            '{6'd30, ONE - 64'd1,           1'b0, 64'd0,          1'b0},
            '{6'd30, ONE + 64'd1,           1'b1, ONE,            1'b0},
            '{6'd30, ALL_ONES,              1'b0, 64'd0,          1'b0},
            '{6'd30, 64'h4_0000_0000,       1'b0, 64'd0,          1'b0},
            '{6'd30, 64'h4000_0000,         1'b0, 64'd0,          1'b0},
            '{6'd30, 64'h8000_0000_0000_0000, 1'b0, 64'd0,        1'b0},
            '{6'd30, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0,        1'b0},
            '{6'd30, 64'h5555_5555_5555_5555, 1'b0, 64'd0,        1'b0},
            '{6'd0,  64'd0,                 1'b1, 64'd0,          1'b0},
            '{6'd0,  ALL_ONES,              1'b1, ONE,            1'b0},
            '{6'd0,  64'h1234_5678,         1'b1, 64'h1234_5678,  1'b0},
            '{6'd0,  64'h9_0000_0000,       1'b1, ONE,            1'b0},
            '{6'd62, 64'd0,                 1'b0, 64'd0,          1'b0},
            '{6'd62, ALL_ONES,              1'b0, 64'd0,          1'b0},
            '{6'd62, 64'h2_0000_0000,       1'b0, 64'd0,          1'b0},
            '{6'd62, 64'd1,                 1'b0, 64'd0,          1'b0},
            '{6'd62, 64'hFFFF_FFFE_0000_0001, 1'b0, 64'd0,        1'b0},
            '{6'd1,  ALL_ONES,              1'b0, 64'd0,          1'b0},
            '{6'd1,  64'h8000_0000,         1'b0, 64'd0,          1'b0},
            '{6'd1,  64'd0,                 1'b0, 64'd0,          1'b0},
            '{6'd63, 64'h1_0000_0000_0000,  1'b0, 64'd0,          1'b0},
            '{6'd63, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0,        1'b0}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].k != tol_model)
            begin
                wait_drained();
                write_tolerance(directed_rows[i].k);
            end
            send_operand(directed_rows[i].operand, directed_rows[i].typed,
                         directed_rows[i].root, directed_rows[i].exact_hit);
        end

        for (phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: k = 6'd1;
                1: k = 6'd62;
                2: k = 6'd0;
                3: k = 6'd63;
                9: k = TOL_RESET;
                default: k = tol_shift_t'($urandom_range(1, 62));
            endcase
            wait_drained();
            write_tolerance(k);
            for (n = 0; n < 125; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: x = {$urandom, $urandom};
                    4: x = {32'd0, $urandom};
                    5: x = 64'($urandom_range(0, 15));
                    6:
                    begin
                        m = {16'd0, 16'($urandom), $urandom} >> $urandom_range(0, 40);
                        x = square_q(m) + 64'($urandom_range(0, 3));
                    end
                    7: x = 64'h1 << $urandom_range(0, 63);
                    8:
                    begin
                        case ($urandom_range(0, 5))
                            0: x = 64'd0;
                            1: x = 64'd1;
                            2: x = ONE;
                            3: x = ALL_ONES;
                            4: x = ONE - 64'd1;
                            default: x = ONE + 64'd1;
                        endcase
                    end
                    default: x = {32'hFFFF_FFFF ^ 32'($urandom_range(0, 255)), $urandom};
                endcase
                if (n % 50 == 49)
                    wait_drained();
                send_operand(x, 1'b0, 64'd0, 1'b0);
            end
        end

        request_if.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_roots.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
